// ===== rtl/pss_pkg.sv =====
// pose settle sample sequencer: shared types, constants and the pose table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

	localparam int NUM_POSES_DEF  = 39;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int PIDX_W         = 6;
	localparam int LABEL_W        = 7;
	localparam int TIMER_W        = 16;
	localparam int TOL_W          = 15;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 32;

	// register indexes
	localparam logic [2:0] REG_STARTUP_MODE     = 3'd0;
	localparam logic [2:0] REG_SETTLE_TICKS     = 3'd1;
	localparam logic [2:0] REG_HOLD_TICKS       = 3'd2;
	localparam logic [2:0] REG_MOVE_TIMEOUT     = 3'd3;
	localparam logic [2:0] REG_TOLERANCE        = 3'd4;
	localparam logic [2:0] REG_STARTUP_TIMEOUT  = 3'd5;
	localparam logic [2:0] REG_STARTUP_HOLD     = 3'd6;
	localparam logic [2:0] REG_STARTUP_TOL      = 3'd7;

	// sequencer modes
	localparam logic [2:0] MODE_CHECK = 3'd0;
	localparam logic [2:0] MODE_ZERO  = 3'd1;
	localparam logic [2:0] MODE_POSES = 3'd2;
	localparam logic [2:0] MODE_DONE  = 3'd3;
	localparam logic [2:0] MODE_FAIL  = 3'd4;

	// startup selections
	localparam logic [1:0] START_NONE = 2'd0;
	localparam logic [1:0] START_ZERO = 2'd1;

	localparam logic [1:0] STATUS_RUN  = 2'd0;
	localparam logic [1:0] STATUS_DONE = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	localparam logic [LABEL_W-1:0] LABEL_NONE = '1;

	localparam logic signed [15:0] CHECK_ARM1 = -16'sd500;

	// register reset values
	localparam logic [1:0]         RST_STARTUP_MODE    = 2'd2;
	localparam logic [TIMER_W-1:0] RST_SETTLE_TICKS    = 16'd15;
	localparam logic [TIMER_W-1:0] RST_HOLD_TICKS      = 16'd75;
	localparam logic [TIMER_W-1:0] RST_MOVE_TIMEOUT    = 16'd450;
	localparam logic [TOL_W-1:0]   RST_TOLERANCE       = 15'd100;
	localparam logic [TIMER_W-1:0] RST_STARTUP_TIMEOUT = 16'd600;
	localparam logic [TIMER_W-1:0] RST_STARTUP_HOLD    = 16'd15;
	localparam logic [TOL_W-1:0]   RST_STARTUP_TOL     = 15'd100;

	typedef struct packed {
		logic [1:0]         startup_mode;
		logic [TIMER_W-1:0] settle_ticks;
		logic [TIMER_W-1:0] hold_ticks;
		logic [TIMER_W-1:0] move_timeout_ticks;
		logic [TOL_W-1:0]   tolerance_cdeg;
		logic [TIMER_W-1:0] startup_timeout_ticks;
		logic [TIMER_W-1:0] startup_hold_ticks;
		logic [TOL_W-1:0]   startup_tolerance_cdeg;
	} cfg_t;

	typedef struct packed {
		logic       restart;
		logic [1:0] startup_mode;
	} cfg_ctl_t;

	typedef struct packed {
		logic signed [15:0] arm2;
		logic signed [15:0] arm1;
	} pose_t;

	function automatic pose_t pp(input int a1, input int a2);
		pose_t p;
		p.arm1 = 16'(a1);
		p.arm2 = 16'(a2);
		return p;
	endfunction

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		return (v == '1) ? v : v + TIMER_W'(1);
	endfunction

	function automatic logic [2:0] start_mode(input logic [1:0] sel);
		logic [2:0] m;
		case (sel)
			START_ZERO: m = MODE_ZERO;
			START_NONE: m = MODE_POSES;
			default:    m = MODE_CHECK;
		endcase
		return m;
	endfunction

	function automatic pose_t pose_entry(input logic [PIDX_W-1:0] idx);
		pose_t p;
		case (idx)
			6'd0:  p = pp(-6000, 0);
			6'd1:  p = pp(-4500, 0);
			6'd2:  p = pp(-3000, 0);
			6'd3:  p = pp(-1500, 0);
			6'd4:  p = pp(0, 0);
			6'd5:  p = pp(1500, 0);
			6'd6:  p = pp(3000, 0);
			6'd7:  p = pp(4500, 0);
			6'd8:  p = pp(6000, 0);
			6'd9:  p = pp(6000, 500);
			6'd10: p = pp(4000, 500);
			6'd11: p = pp(2000, 500);
			6'd12: p = pp(0, 500);
			6'd13: p = pp(-2000, 500);
			6'd14: p = pp(-4000, 500);
			6'd15: p = pp(-6000, 500);
			6'd16: p = pp(-6000, 1000);
			6'd17: p = pp(-4000, 1000);
			6'd18: p = pp(-2000, 1000);
			6'd19: p = pp(0, 1000);
			6'd20: p = pp(2000, 1000);
			6'd21: p = pp(4000, 1000);
			6'd22: p = pp(6000, 1000);
			6'd23: p = pp(4500, 1500);
			6'd24: p = pp(2000, 1500);
			6'd25: p = pp(0, 1500);
			6'd26: p = pp(-2000, 1500);
			6'd27: p = pp(-4500, 1500);
			6'd28: p = pp(-4500, -1000);
			6'd29: p = pp(-2000, -1000);
			6'd30: p = pp(0, -1000);
			6'd31: p = pp(2000, -1000);
			6'd32: p = pp(4500, -1000);
			6'd33: p = pp(3000, -2000);
			6'd34: p = pp(0, -2000);
			6'd35: p = pp(-3000, -2000);
			6'd36: p = pp(2000, -3000);
			6'd37: p = pp(0, -3000);
			6'd38: p = pp(-2000, -3000);
			default: p = pp(0, 0);
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pss_if.sv =====
// pose settle sample sequencer: valid/ready channel interfaces
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pss_in_if import pss_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         feedback_seen;
	logic signed [ANGLE_BITS-1:0] arm1_reading;
	logic signed [ANGLE_BITS-1:0] arm2_reading;
	logic signed [ANGLE_BITS-1:0] hand_reading;

	modport source (
		output valid, feedback_seen, arm1_reading, arm2_reading, hand_reading,
		input  ready
	);
	modport sink (
		input  valid, feedback_seen, arm1_reading, arm2_reading, hand_reading,
		output ready
	);
endinterface

interface pss_out_if import pss_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] arm1_target;
	logic signed [ANGLE_BITS-1:0] arm2_target;
	logic signed [ANGLE_BITS-1:0] hand_target;
	logic signed [LABEL_W-1:0]    sample_label;
	logic [1:0]                   run_status;

	modport source (
		output valid, arm1_target, arm2_target, hand_target, sample_label, run_status,
		input  ready
	);
	modport sink (
		input  valid, arm1_target, arm2_target, hand_target, sample_label, run_status,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/pss_cfg.sv =====
// pose settle sample sequencer: APB configuration registers
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pss_cfg import pss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg,
	output cfg_ctl_t                   ctl
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	assign ctl.restart      = wr_en && (idx == REG_STARTUP_MODE);
	assign ctl.startup_mode = pwdata[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_mode           <= RST_STARTUP_MODE;
			cfg_q.settle_ticks           <= RST_SETTLE_TICKS;
			cfg_q.hold_ticks             <= RST_HOLD_TICKS;
			cfg_q.move_timeout_ticks     <= RST_MOVE_TIMEOUT;
			cfg_q.tolerance_cdeg         <= RST_TOLERANCE;
			cfg_q.startup_timeout_ticks  <= RST_STARTUP_TIMEOUT;
			cfg_q.startup_hold_ticks     <= RST_STARTUP_HOLD;
			cfg_q.startup_tolerance_cdeg <= RST_STARTUP_TOL;
		end else if (wr_en) begin
			case (idx)
				REG_STARTUP_MODE:    cfg_q.startup_mode           <= pwdata[1:0];
				REG_SETTLE_TICKS:    cfg_q.settle_ticks           <= pwdata[TIMER_W-1:0];
				REG_HOLD_TICKS:      cfg_q.hold_ticks             <= pwdata[TIMER_W-1:0];
				REG_MOVE_TIMEOUT:    cfg_q.move_timeout_ticks     <= pwdata[TIMER_W-1:0];
				REG_TOLERANCE:       cfg_q.tolerance_cdeg         <= pwdata[TOL_W-1:0];
				REG_STARTUP_TIMEOUT: cfg_q.startup_timeout_ticks  <= pwdata[TIMER_W-1:0];
				REG_STARTUP_HOLD:    cfg_q.startup_hold_ticks     <= pwdata[TIMER_W-1:0];
				REG_STARTUP_TOL:     cfg_q.startup_tolerance_cdeg <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STARTUP_MODE:    prdata = CFG_DATA_W'(cfg_q.startup_mode);
			REG_SETTLE_TICKS:    prdata = CFG_DATA_W'(cfg_q.settle_ticks);
			REG_HOLD_TICKS:      prdata = CFG_DATA_W'(cfg_q.hold_ticks);
			REG_MOVE_TIMEOUT:    prdata = CFG_DATA_W'(cfg_q.move_timeout_ticks);
			REG_TOLERANCE:       prdata = CFG_DATA_W'(cfg_q.tolerance_cdeg);
			REG_STARTUP_TIMEOUT: prdata = CFG_DATA_W'(cfg_q.startup_timeout_ticks);
			REG_STARTUP_HOLD:    prdata = CFG_DATA_W'(cfg_q.startup_hold_ticks);
			REG_STARTUP_TOL:     prdata = CFG_DATA_W'(cfg_q.startup_tolerance_cdeg);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pss_step.sv =====
// pose settle sample sequencer: sequencer state and the per-tick update
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

module pss_step import pss_pkg::*; #(
	parameter int NUM_POSES  = NUM_POSES_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cfg_t                         cfg,
	input  wire cfg_ctl_t                     ctl,
	input  wire logic                         step,
	input  wire logic                         feedback_seen,
	input  wire logic signed [ANGLE_BITS-1:0] arm1_reading,
	input  wire logic signed [ANGLE_BITS-1:0] arm2_reading,
	input  wire logic signed [ANGLE_BITS-1:0] hand_reading,
	output logic signed      [ANGLE_BITS-1:0] arm1_target,
	output logic signed      [ANGLE_BITS-1:0] arm2_target,
	output logic signed      [ANGLE_BITS-1:0] hand_target,
	output logic signed      [LABEL_W-1:0]    sample_label,
	output logic             [1:0]            run_status
);

	localparam int DW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
	localparam logic [PIDX_W-1:0] LAST_POSE = PIDX_W'(NUM_POSES - 1);

	logic [2:0]                    mode_q, mode_n;
	logic [PIDX_W-1:0]             idx_q, idx_n;
	logic [TIMER_W-1:0]            ph_q, ph_n, st_q, st_n, wt_q, wt_n;
	logic                          sa_q, sa_n, win_q, win_n, latched_q, latched_n;
	logic signed [ANGLE_BITS-1:0]  hold_q, hold_n;

	pose_t                         pose;
	logic signed [15:0]            tg1, tg2;
	logic signed [DW-1:0]          t1x, t2x, d1, d2;
	logic [DW-1:0]                 e1, e2, worst;
	logic                          within_s, within_p, check_done, zero_done, term;

	always_comb begin
		mode_n    = mode_q;
		idx_n     = idx_q;
		ph_n      = ph_q;
		st_n      = st_q;
		wt_n      = wt_q;
		sa_n      = sa_q;
		win_n     = win_q;
		latched_n = latched_q;
		hold_n    = hold_q;

		// wrist latch on the first reading
		if (!latched_q && feedback_seen) begin
			hold_n    = hand_reading;
			latched_n = 1'b1;
		end

		pose = pose_entry(idx_q);
		term = (mode_q == MODE_DONE) || (mode_q == MODE_FAIL);
		sample_label = LABEL_NONE;
		run_status   = STATUS_RUN;

		case (mode_q)
			MODE_CHECK: begin
				tg1 = CHECK_ARM1;
				tg2 = '0;
			end
			MODE_POSES: begin
				tg1 = pose.arm1;
				tg2 = pose.arm2;
				if (win_q)
					sample_label = {1'b0, idx_q};
			end
			default: begin
				tg1 = '0;
				tg2 = '0;
			end
		endcase

		t1x   = {{(DW-16){tg1[15]}}, tg1};
		t2x   = {{(DW-16){tg2[15]}}, tg2};
		d1    = t1x - {{(DW-ANGLE_BITS){arm1_reading[ANGLE_BITS-1]}}, arm1_reading};
		d2    = t2x - {{(DW-ANGLE_BITS){arm2_reading[ANGLE_BITS-1]}}, arm2_reading};
		e1    = d1[DW-1] ? DW'(-d1) : DW'(d1);
		e2    = d2[DW-1] ? DW'(-d2) : DW'(d2);
		worst = (e1 > e2) ? e1 : e2;
		within_s = worst <= DW'(cfg.startup_tolerance_cdeg);
		within_p = worst <= DW'(cfg.tolerance_cdeg);

		check_done = 1'b0;
		zero_done  = 1'b0;

		if (term) begin
			tg1 = '0;
			tg2 = '0;
			t1x = '0;
			t2x = '0;
			sample_label = LABEL_NONE;
			run_status   = (mode_q == MODE_DONE) ? STATUS_DONE : STATUS_FAIL;
		end else if (feedback_seen) begin
			if (mode_q != MODE_POSES) begin
				if (within_s) begin
					if (!sa_n) begin
						sa_n = 1'b1;
						st_n = '0;
					end
					if (st_n >= cfg.startup_hold_ticks) begin
						if (mode_q == MODE_CHECK) begin
							mode_n     = MODE_ZERO;
							check_done = 1'b1;
						end else begin
							mode_n    = MODE_POSES;
							win_n     = 1'b0;
							wt_n      = '0;
							zero_done = 1'b1;
						end
						sa_n = 1'b0;
						st_n = '0;
					end
				end else begin
					sa_n = 1'b0;
				end
				if (check_done) begin
					ph_n = '0;
				end else if (ph_q > cfg.startup_timeout_ticks) begin
					mode_n     = MODE_FAIL;
					run_status = STATUS_FAIL;
				end else if (zero_done) begin
					ph_n = '0;
				end
			end else if (!win_q) begin
				if (within_p) begin
					if (!sa_n) begin
						sa_n = 1'b1;
						st_n = '0;
					end
					if (st_n >= cfg.settle_ticks) begin
						win_n = 1'b1;
						wt_n  = '0;
					end
				end else begin
					sa_n = 1'b0;
				end
				if (ph_q > cfg.move_timeout_ticks) begin
					mode_n     = MODE_FAIL;
					run_status = STATUS_FAIL;
				end
			end else if (wt_q >= cfg.hold_ticks) begin
				idx_n = idx_q + PIDX_W'(1);
				win_n = 1'b0;
				ph_n  = '0;
				sa_n  = 1'b0;
				st_n  = '0;
				if (idx_q == LAST_POSE)
					mode_n = MODE_DONE;
			end
		end

		if (!term) begin
			ph_n = sat_inc(ph_n);
			if (win_n)
				wt_n = sat_inc(wt_n);
			if (sa_n)
				st_n = sat_inc(st_n);
		end

		arm1_target = t1x[ANGLE_BITS-1:0];
		arm2_target = t2x[ANGLE_BITS-1:0];
		hand_target = hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= start_mode(RST_STARTUP_MODE);
			idx_q     <= '0;
			ph_q      <= '0;
			st_q      <= '0;
			wt_q      <= '0;
			sa_q      <= 1'b0;
			win_q     <= 1'b0;
			latched_q <= 1'b0;
			hold_q    <= '0;
		end else if (ctl.restart) begin
			mode_q    <= start_mode(ctl.startup_mode);
			idx_q     <= '0;
			ph_q      <= '0;
			st_q      <= '0;
			wt_q      <= '0;
			sa_q      <= 1'b0;
			win_q     <= 1'b0;
			latched_q <= 1'b0;
			hold_q    <= '0;
		end else if (step) begin
			mode_q    <= mode_n;
			idx_q     <= idx_n;
			ph_q      <= ph_n;
			st_q      <= st_n;
			wt_q      <= wt_n;
			sa_q      <= sa_n;
			win_q     <= win_n;
			latched_q <= latched_n;
			hold_q    <= hold_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pose_settle_sample_sequencer.sv =====
// pose settle sample sequencer: top level with input stage and result register
// depends on pss_pkg, pss_if, pss_cfg, pss_step
//
// usage: one request on the sensor channel per control tick carries the feedback
// flag and the two joint and wrist readings; for each request exactly one result
// leaves on the command channel with the joint targets, the latched wrist target,
// the sample label (pose index while the hold window is open, else -1) and the
// run status. the request is caught in an input register and the tick update
// runs combinationally between that register and the result register; a new
// request is taken in every cycle while the receiver does not stall. when the
// receiver stalls the result register holds its item, the input register takes
// one more request and then ready drops until the result is taken. reset clears
// both stages and the sequence state and loads the register defaults; writing
// startup_mode over the APB port restarts the sequence. the user must write
// configuration only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module pose_settle_sample_sequencer import pss_pkg::*; #(
	parameter int NUM_POSES  = NUM_POSES_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pss_in_if.sink                     sensor,
	pss_out_if.source                  command,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t     cfg;
	cfg_ctl_t ctl;

	logic                         valid_s1, fb_s1;
	logic signed [ANGLE_BITS-1:0] r1_s1, r2_s1, rh_s1;
	logic                         adv;

	logic                         out_valid_q;
	logic signed [ANGLE_BITS-1:0] t1_q, t2_q, th_q;
	logic signed [LABEL_W-1:0]    label_q;
	logic [1:0]                   status_q;

	logic signed [ANGLE_BITS-1:0] t1, t2, th;
	logic signed [LABEL_W-1:0]    label;
	logic [1:0]                   status;

	pss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.ctl     (ctl)
	);

	pss_step #(
		.NUM_POSES  (NUM_POSES),
		.ANGLE_BITS (ANGLE_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.ctl           (ctl),
		.step          (adv),
		.feedback_seen (fb_s1),
		.arm1_reading  (r1_s1),
		.arm2_reading  (r2_s1),
		.hand_reading  (rh_s1),
		.arm1_target   (t1),
		.arm2_target   (t2),
		.hand_target   (th),
		.sample_label  (label),
		.run_status    (status)
	);

	assign adv          = valid_s1 && (!out_valid_q || command.ready);
	assign sensor.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sensor.ready)
			valid_s1 <= sensor.valid;
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			fb_s1 <= sensor.feedback_seen;
			r1_s1 <= sensor.arm1_reading;
			r2_s1 <= sensor.arm2_reading;
			rh_s1 <= sensor.hand_reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (command.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_q     <= t1;
			t2_q     <= t2;
			th_q     <= th;
			label_q  <= label;
			status_q <= status;
		end
	end

	assign command.valid        = out_valid_q;
	assign command.arm1_target  = t1_q;
	assign command.arm2_target  = t2_q;
	assign command.hand_target  = th_q;
	assign command.sample_label = label_q;
	assign command.run_status   = status_q;

endmodule

`default_nettype wire
